### sv/header_length_sum_deframer_assert.svh
// Assertion macros for the header length sum deframer.
`ifndef HEADER_LENGTH_SUM_DEFRAMER_ASSERT_SVH
`define HEADER_LENGTH_SUM_DEFRAMER_ASSERT_SVH
`ifndef SYNTH
`define HLSD_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define HLSD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HLSD_ASSERT(lbl, clk, rst_n, prop, msg)
`define HLSD_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

### sv/hlsd_pkg.sv
// Shared types and constants of the header length sum deframer.
`timescale 1ns / 1ps
package hlsd_pkg;
	localparam int MAX_PAYLOAD_DEF = 14;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEADER = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SUM_CHECK_EN = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_COPY_LIMIT   = 2'd2;

	localparam logic [3:0] COPY_LIMIT_RST = 4'd14;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_SUM_ERR = 2'd1;
	localparam logic [1:0] ST_LEN_ERR = 2'd2;

	typedef struct packed {
		logic [15:0] header;
		logic        check_en;
		logic [3:0]  copy_limit;
	} cfg_t;

	typedef struct packed {
		logic        fire;
		logic [1:0]  status;
		logic [7:0]  length;
		logic [63:0] payload_low;
		logic [47:0] payload_high;
		logic [7:0]  sum;
	} res_t;
endpackage

### sv/hlsd_framer.sv
// Framing state machine: header hunt, length check, payload capture and sum check.
`timescale 1ns / 1ps
module hlsd_framer #(
	parameter int MAX_PAYLOAD = hlsd_pkg::MAX_PAYLOAD_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic [7:0]       rx_byte,
	input  hlsd_pkg::cfg_t   cfg,
	output hlsd_pkg::res_t   res
);
	import hlsd_pkg::*;

	localparam logic [1:0] PH_HUNT    = 2'd0;
	localparam logic [1:0] PH_LEN     = 2'd1;
	localparam logic [1:0] PH_PAYLOAD = 2'd2;
	localparam logic [1:0] PH_SUM     = 2'd3;

	logic [1:0] phase_q, phase_d;
	logic [7:0] prev_q, prev_d;
	logic       prev_valid_q, prev_valid_d;
	logic [3:0] exp_q, exp_d;
	logic [3:0] taken_q, taken_d;
	logic [3:0] taken_inc;
	logic [7:0] sum_q, sum_d;
	logic       clear, wr_en;
	logic [7:0] store_q [MAX_PAYLOAD];
	logic [7:0] store_d [MAX_PAYLOAD];
	logic [63:0] pay_lo;
	logic [47:0] pay_hi;

	assign taken_inc = taken_q + 4'd1;

	always_comb begin
		phase_d      = phase_q;
		prev_d       = prev_q;
		prev_valid_d = prev_valid_q;
		exp_d        = exp_q;
		taken_d      = taken_q;
		sum_d        = sum_q;
		clear        = 1'b0;
		wr_en        = 1'b0;
		res.fire     = 1'b0;
		res.status   = ST_OK;
		case (phase_q)
			PH_HUNT: begin
				if (prev_valid_q && {prev_q, rx_byte} == cfg.header) begin
					sum_d        = prev_q + rx_byte;
					clear        = 1'b1;
					taken_d      = 4'd0;
					exp_d        = 4'd0;
					prev_valid_d = 1'b0;
					phase_d      = PH_LEN;
				end else begin
					prev_d       = rx_byte;
					prev_valid_d = 1'b1;
				end
			end
			PH_LEN: begin
				sum_d = sum_q + rx_byte;
				if (rx_byte > 8'(MAX_PAYLOAD)) begin
					res.fire   = 1'b1;
					res.status = ST_LEN_ERR;
				end else begin
					exp_d   = rx_byte[3:0];
					taken_d = 4'd0;
					if (rx_byte == 8'd0) begin
						if (cfg.check_en) begin
							phase_d = PH_SUM;
						end else begin
							res.fire = 1'b1;
						end
					end else begin
						phase_d = PH_PAYLOAD;
					end
				end
			end
			PH_PAYLOAD: begin
				sum_d   = sum_q + rx_byte;
				wr_en   = (taken_q < cfg.copy_limit) && (taken_q < 4'(MAX_PAYLOAD));
				taken_d = taken_inc;
				if (taken_inc >= exp_q) begin
					if (cfg.check_en) begin
						phase_d = PH_SUM;
					end else begin
						res.fire = 1'b1;
					end
				end
			end
			default: begin
				res.fire   = 1'b1;
				res.status = (rx_byte == sum_q) ? ST_OK : ST_SUM_ERR;
			end
		endcase
		if (res.fire) begin
			phase_d      = PH_HUNT;
			prev_valid_d = 1'b0;
			prev_d       = 8'd0;
		end
		res.length       = (res.status == ST_LEN_ERR) ? rx_byte : {4'd0, exp_d};
		res.sum          = sum_d;
		res.payload_low  = pay_lo;
		res.payload_high = pay_hi;
	end

	for (genvar i = 0; i < MAX_PAYLOAD; i++) begin : g_store
		always_comb begin
			if (clear) begin
				store_d[i] = 8'd0;
			end else if (wr_en && taken_q == 4'(i)) begin
				store_d[i] = rx_byte;
			end else begin
				store_d[i] = store_q[i];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				store_q[i] <= 8'd0;
			end else if (step) begin
				store_q[i] <= store_d[i];
			end
		end
	end

	for (genvar i = 0; i < 8; i++) begin : g_lo
		if (i < MAX_PAYLOAD) begin : g_used
			assign pay_lo[8*i +: 8] = store_d[i];
		end else begin : g_zero
			assign pay_lo[8*i +: 8] = 8'd0;
		end
	end

	for (genvar i = 0; i < 6; i++) begin : g_hi
		if (i + 8 < MAX_PAYLOAD) begin : g_used
			assign pay_hi[8*i +: 8] = store_d[i+8];
		end else begin : g_zero
			assign pay_hi[8*i +: 8] = 8'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_HUNT;
			prev_q       <= 8'd0;
			prev_valid_q <= 1'b0;
			exp_q        <= 4'd0;
			taken_q      <= 4'd0;
			sum_q        <= 8'd0;
		end else if (step) begin
			phase_q      <= phase_d;
			prev_q       <= prev_d;
			prev_valid_q <= prev_valid_d;
			exp_q        <= exp_d;
			taken_q      <= taken_d;
			sum_q        <= sum_d;
		end
	end
endmodule

### sv/header_length_sum_deframer.sv
// Top level of the header length sum deframer: input register, framer, result register.
// Accepts one received byte per cycle while rx_stall is low and emits one result per finished
// or rejected frame. The byte that ends a frame is held in the input register, and its result
// is held in the result register; the byte rate is set by the framing state update between the
// input register and the result register. While a result waits under res_stall the framer
// holds: the input register still takes one byte, then rx_stall stays high until the result
// leaves. Configuration writes are taken in any cycle and should happen only while idle.
`timescale 1ns / 1ps
`include "header_length_sum_deframer_assert.svh"
module header_length_sum_deframer #(
	parameter int MAX_PAYLOAD = hlsd_pkg::MAX_PAYLOAD_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           rx_valid,
	output logic                           rx_stall,
	input  logic [7:0]                     rx_byte,
	output logic                           res_valid,
	input  logic                           res_stall,
	output logic [1:0]                     status,
	output logic [7:0]                     frame_length,
	output logic [63:0]                    payload_low,
	output logic [47:0]                    payload_high,
	output logic [7:0]                     computed_sum,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [hlsd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [hlsd_pkg::CFG_DATA_W-1:0] cfg_data
);
	import hlsd_pkg::*;

	logic       valid_s1;
	logic [7:0] rx_s1;
	logic       advance;
	logic       rx_take;
	cfg_t       cfg_q;
	res_t       res;

	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && !(res_valid && res_stall);
	assign rx_stall  = valid_s1 && !advance;
	assign rx_take   = rx_valid && !rx_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.header     <= 16'd0;
			cfg_q.check_en   <= 1'b0;
			cfg_q.copy_limit <= COPY_LIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_FRAME_HEADER: cfg_q.header     <= cfg_data;
				CFG_SUM_CHECK_EN: cfg_q.check_en   <= cfg_data[0];
				CFG_COPY_LIMIT:   cfg_q.copy_limit <= cfg_data[3:0];
				default:          cfg_q            <= cfg_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_take) begin
			rx_s1 <= rx_byte;
		end
	end

	hlsd_framer #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) u_framer (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.rx_byte(rx_s1),
		.cfg    (cfg_q),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (advance && res.fire) begin
			res_valid <= 1'b1;
		end else if (!res_stall) begin
			res_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.fire) begin
			status       <= res.status;
			frame_length <= res.length;
			payload_low  <= res.payload_low;
			payload_high <= res.payload_high;
			computed_sum <= res.sum;
		end
	end

	`HLSD_ASSERT(a_status_code, clk, arst_n, res_valid |-> (status != 2'd3), "bad status code")
	`HLSD_ASSERT(a_len_err_empty, clk, arst_n, (res_valid && status == ST_LEN_ERR) |-> (payload_low == 64'd0 && payload_high == 48'd0), "payload on rejected length")
	`HLSD_ASSERT(a_len_legal, clk, arst_n, (res_valid && status != ST_LEN_ERR) |-> (frame_length <= 8'(MAX_PAYLOAD)), "accepted length above limit")
	`HLSD_ASSERT_ALWAYS(a_reset_idle, clk, !arst_n |-> (!res_valid && !valid_s1), "pipeline busy in reset")
endmodule
